>>> rtl/mjpeg_frame_extractor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame extractor
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MJPEG_FRAME_EXTRACTOR_ASSERT_SVH
`define MJPEG_FRAME_EXTRACTOR_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define MFE_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the following cycle.
`define MFE_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mfe_pkg.sv
// ----------------------------------------------------------------------------
// Frame extractor package
// Marker codes, register reset value and the command passed from the
// classifier to the output sequencer.
// ----------------------------------------------------------------------------
package mfe_pkg;

    localparam logic [7:0]  MARK_FF  = 8'hFF;
    localparam logic [7:0]  MARK_SOI = 8'hD8;
    localparam logic [7:0]  MARK_EOI = 8'hD9;
    localparam logic [23:0] DEFAULT_MAX_FRAME = 24'd524288;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2,
        CMD_DROP  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [23:0] length;
    } cmd_t;

endpackage

>>> rtl/mfe_front.sv
// ----------------------------------------------------------------------------
// Frame extractor classifier
// Accepts stream beats, tracks markers and frame length, and queues one
// command for every beat that produces output.
// ----------------------------------------------------------------------------
`include "mjpeg_frame_extractor_assert.svh"

module mfe_front
    import mfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        end_of_file,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] max_frame_bytes,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        full
);

    logic        in_frame_reg, in_frame_next;
    logic        prev_ff_reg, prev_ff_next;
    logic [23:0] count_reg, count_next;
    logic [23:0] max_reg, max_next;
    logic        accept;
    logic [23:0] count_inc;

    assign in_stall  = full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !full;
    assign count_inc = count_reg + 24'd1;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        prev_ff_next  = prev_ff_reg;
        count_next    = count_reg;
        max_next      = cfg_valid ? max_frame_bytes : max_reg;
        push          = 1'b0;
        push_cmd      = '{kind: CMD_DATA, data: byte_value, length: '0};
        if (accept)
        begin
            if (end_of_file)
            begin
                push          = in_frame_reg;
                push_cmd.kind = CMD_DROP;
                in_frame_next = 1'b0;
                prev_ff_next  = 1'b0;
                count_next    = '0;
            end
            else if (!in_frame_reg)
            begin
                if (prev_ff_reg && byte_value == MARK_SOI)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_START;
                    in_frame_next = 1'b1;
                    count_next    = 24'd2;
                end
                prev_ff_next = (byte_value == MARK_FF);
            end
            else if (count_reg >= max_reg)
            begin
                push          = 1'b1;
                push_cmd.kind = CMD_DROP;
                in_frame_next = 1'b0;
                prev_ff_next  = 1'b0;
                count_next    = '0;
            end
            else if (prev_ff_reg && byte_value == MARK_EOI)
            begin
                push            = 1'b1;
                push_cmd.kind   = CMD_END;
                push_cmd.length = count_inc;
                in_frame_next   = 1'b0;
                prev_ff_next    = 1'b0;
                count_next      = '0;
            end
            else
            begin
                push         = 1'b1;
                count_next   = count_inc;
                prev_ff_next = (byte_value == MARK_FF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            prev_ff_reg  <= 1'b0;
            count_reg    <= '0;
            max_reg      <= DEFAULT_MAX_FRAME;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            prev_ff_reg  <= prev_ff_next;
            count_reg    <= count_next;
            max_reg      <= max_next;
        end
    end

    `MFE_ASSERT(a_hunt_count_zero, in_frame_reg || count_reg == '0, "count nonzero while hunting")
    `MFE_ASSERT(a_frame_count_min, !in_frame_reg || count_reg >= 24'd2, "frame count below two")
    `MFE_ASSERT_NEXT(a_start_enters, push && push_cmd.kind == CMD_START,
        in_frame_reg && count_reg == 24'd2, "start marker did not open a frame")

endmodule

>>> rtl/mfe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Frame extractor command queue
// Small flop-based queue that decouples the classifier from the output
// sequencer.
// ----------------------------------------------------------------------------
`include "mjpeg_frame_extractor_assert.svh"

module mfe_cmd_fifo
    import mfe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `MFE_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
    `MFE_ASSERT(a_no_underflow, !(pop && empty), "pop from an empty queue")

endmodule

>>> rtl/mfe_back.sv
// ----------------------------------------------------------------------------
// Frame extractor output sequencer
// Expands queued commands into result beats and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
`include "mjpeg_frame_extractor_assert.svh"

module mfe_back
    import mfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        pop_cmd,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_start,
    output logic        frame_end,
    output logic        frame_drop,
    output logic [23:0] frame_bytes,
    output logic        last_of_run
);

    logic        out_valid_reg, out_valid_next;
    logic        pending_reg, pending_next;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic        end_reg;
    logic        drop_reg;
    logic [23:0] len_reg;
    logic        last_reg;
    logic        load;

    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !pending_reg && !empty;

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign frame_start = start_reg;
    assign frame_end   = end_reg;
    assign frame_drop  = drop_reg;
    assign frame_bytes = len_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pending_next   = pending_reg;
        if (load)
        begin
            if (pending_reg)
            begin
                out_valid_next = 1'b1;
                pending_next   = 1'b0;
            end
            else
            begin
                out_valid_next = !empty;
                pending_next   = !empty && pop_cmd.kind == CMD_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pending_reg)
        begin
            byte_reg  <= MARK_SOI;
            start_reg <= 1'b0;
            end_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            len_reg   <= '0;
            last_reg  <= 1'b1;
        end
        else if (pop)
        begin
            case (pop_cmd.kind)
                CMD_START:
                begin
                    byte_reg  <= MARK_FF;
                    start_reg <= 1'b1;
                    end_reg   <= 1'b0;
                    drop_reg  <= 1'b0;
                    len_reg   <= '0;
                    last_reg  <= 1'b0;
                end
                CMD_END:
                begin
                    byte_reg  <= pop_cmd.data;
                    start_reg <= 1'b0;
                    end_reg   <= 1'b1;
                    drop_reg  <= 1'b0;
                    len_reg   <= pop_cmd.length;
                    last_reg  <= 1'b1;
                end
                CMD_DROP:
                begin
                    byte_reg  <= '0;
                    start_reg <= 1'b0;
                    end_reg   <= 1'b0;
                    drop_reg  <= 1'b1;
                    len_reg   <= '0;
                    last_reg  <= 1'b1;
                end
                default:
                begin
                    byte_reg  <= pop_cmd.data;
                    start_reg <= 1'b0;
                    end_reg   <= 1'b0;
                    drop_reg  <= 1'b0;
                    len_reg   <= '0;
                    last_reg  <= 1'b1;
                end
            endcase
        end
    end

    `MFE_ASSERT(a_pending_on_start, !pending_reg || (out_valid_reg && start_reg),
        "second marker beat pending without a start beat shown")
    `MFE_ASSERT(a_start_not_last, !(out_valid_reg && start_reg) || !last_reg,
        "start beat marked as last of run")
    `MFE_ASSERT(a_drop_no_data, !(out_valid_reg && drop_reg) || (byte_reg == '0 && last_reg),
        "drop beat carries data")

endmodule

>>> rtl/mjpeg_frame_extractor.sv
// ----------------------------------------------------------------------------
// Motion-JPEG frame extractor
// Input: one stream byte or an end-of-file mark per beat (in_valid/in_stall).
// Output: frame bytes with start, end and drop flags (out_valid/out_stall).
// Configuration: max_frame_bytes is written with cfg_valid and cfg_ready;
// cfg_ready is always high. Writes are to be made only while the block
// is idle; the block itself does not enforce this. The block takes one
// input beat per cycle while in_stall is low. A beat's first result passes
// through the queue and the output register: the classifier writes its
// command into the queue when the beat is accepted, and the sequencer then
// moves it into the output register. A start marker yields two output
// beats; every other beat yields at most one. The command queue of
// QUEUE_DEPTH entries absorbs that and short receiver stalls. When
// out_stall is high the output beat holds and the queue fills; in_stall
// rises once it is full. After reset the block hunts for a start marker,
// max_frame_bytes is 524288 and the queue and output register are empty.
// ----------------------------------------------------------------------------
module mjpeg_frame_extractor
    import mfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        end_of_file,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] max_frame_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_start,
    output logic        frame_end,
    output logic        frame_drop,
    output logic [23:0] frame_bytes,
    output logic        last_of_run
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t pop_cmd;
    logic empty;

    mfe_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_value      (byte_value),
        .end_of_file     (end_of_file),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_frame_bytes (max_frame_bytes),
        .push            (push),
        .push_cmd        (push_cmd),
        .full            (full)
    );

    mfe_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    mfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_cmd     (pop_cmd),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .frame_drop  (frame_drop),
        .frame_bytes (frame_bytes),
        .last_of_run (last_of_run)
    );

endmodule

>>> tb/sv/tb_mjpeg_frame_extractor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Motion-JPEG frame extractor
// A stream of bytes and end-of-file marks is driven into the block, first
// from a short table of cases (markers, end of file, overflow at limits
// of zero to three) and then as random frames with noise, broken endings
// and several limit settings. A cycle-free model of the splitter predicts
// each output beat unless a table row gives its own. Output beats are
// compared in order. Both sides idle and stall at random, and the
// receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_mjpeg_frame_extractor;
    import mfe_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        opens;
        logic        closes;
        logic        dropped;
        logic [23:0] total;
        logic        last;
    } frame_beat_t;

    typedef enum {ROW_BYTE, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [23:0] value;
        logic        is_eof;
        bit          typed;
        int          n_beats;
        frame_beat_t first_beat;
        frame_beat_t second_beat;
    } stim_row_t;

    localparam frame_beat_t DROP_BEAT = '{data: 8'h00, opens: 1'b0, closes: 1'b0,
                                          dropped: 1'b1, total: 24'd0, last: 1'b1};
    localparam frame_beat_t OPEN_FF_BEAT = '{data: MARK_FF, opens: 1'b1, closes: 1'b0,
                                             dropped: 1'b0, total: 24'd0, last: 1'b0};
    localparam frame_beat_t OPEN_SOI_BEAT = '{data: MARK_SOI, opens: 1'b0, closes: 1'b0,
                                              dropped: 1'b0, total: 24'd0, last: 1'b1};
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 120;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_value;
    logic        end_of_file;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] max_frame_bytes;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        frame_start;
    logic        frame_end;
    logic        frame_drop;
    logic [23:0] frame_bytes;
    logic        last_of_run;

    logic        frame_open;
    logic        ff_pending;
    logic [23:0] frame_len;
    logic [23:0] len_limit;

    frame_beat_t frame_beats_due[$];
    stim_row_t   directed_rows[$];
    logic [23:0] phase_limits[5] = '{DEFAULT_MAX_FRAME, 24'd12, 24'd2, 24'd40, 24'hFFFFFF};
    int          sent_items;
    int          beats_out;
    int          mismatch_count;
    bit          steady;

    mjpeg_frame_extractor uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_value      (byte_value),
        .end_of_file     (end_of_file),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_frame_bytes (max_frame_bytes),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .frame_start     (frame_start),
        .frame_end       (frame_end),
        .frame_drop      (frame_drop),
        .frame_bytes     (frame_bytes),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void start_hunt();
        frame_open = 1'b0;
        ff_pending = 1'b0;
        frame_len = 24'd0;
    endfunction

    function automatic int split_byte(input logic [7:0] b, input logic eof_in,
                                      output frame_beat_t r0, output frame_beat_t r1);
        int n;
        n = 0;
        r0 = '0;
        r1 = '0;
        if (eof_in)
        begin
            if (frame_open)
            begin
                r0.dropped = 1'b1;
                n = 1;
            end
            start_hunt();
        end
        else if (!frame_open)
        begin
            if (ff_pending && b == MARK_SOI)
            begin
                r0.data = MARK_FF;
                r0.opens = 1'b1;
                r1.data = MARK_SOI;
                n = 2;
                frame_open = 1'b1;
                frame_len = 24'd2;
            end
            ff_pending = (b == MARK_FF);
        end
        else if (frame_len >= len_limit)
        begin
            r0.dropped = 1'b1;
            n = 1;
            start_hunt();
        end
        else
        begin
            frame_len = frame_len + 24'd1;
            r0.data = b;
            n = 1;
            if (ff_pending && b == MARK_EOI)
            begin
                r0.closes = 1'b1;
                r0.total = frame_len;
                start_hunt();
            end
            else
            begin
                ff_pending = (b == MARK_FF);
            end
        end
        if (n == 1)
            r0.last = 1'b1;
        else if (n == 2)
            r1.last = 1'b1;
        return n;
    endfunction

    function automatic stim_row_t item_row(logic [7:0] b, logic eof_in);
        stim_row_t row;
        row = '{kind: ROW_BYTE, value: {16'd0, b}, is_eof: eof_in, typed: 1'b0,
                n_beats: 0, first_beat: '0, second_beat: '0};
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] b, logic eof_in, int n,
                                            frame_beat_t b0, frame_beat_t b1);
        stim_row_t row;
        row = '{kind: ROW_BYTE, value: {16'd0, b}, is_eof: eof_in, typed: 1'b1,
                n_beats: n, first_beat: b0, second_beat: b1};
        return row;
    endfunction

    function automatic stim_row_t limit_row(logic [23:0] v);
        stim_row_t row;
        row = '{kind: ROW_LIMIT, value: v, is_eof: 1'b0, typed: 1'b0,
                n_beats: 0, first_beat: '0, second_beat: '0};
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void expect_beat(input frame_beat_t beat);
        frame_beats_due.insert(frame_beats_due.size(), beat);
    endfunction

    function automatic logic [7:0] random_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return MARK_FF;
        else if (r < 22)
            return MARK_SOI;
        else if (r < 27)
            return MARK_EOI;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_item(input stim_row_t row);
        frame_beat_t r0;
        frame_beat_t r1;
        int n;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_value <= row.value[7:0];
        end_of_file <= row.is_eof;
        do
            @(posedge clk);
        while (in_stall);
        sent_items++;
        n = split_byte(row.value[7:0], row.is_eof, r0, r1);
        if (row.typed)
        begin
            n = row.n_beats;
            r0 = row.first_beat;
            r1 = row.second_beat;
        end
        if (n > 0)
            expect_beat(r0);
        if (n > 1)
            expect_beat(r1);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_beats_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [23:0] v);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        max_frame_bytes <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        len_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sequence();
        int ending;
        int body;
        repeat ($urandom_range(0, 3)) send_item(item_row(random_byte(), 1'b0));
        if ($urandom_range(0, 19) == 0)
            send_item(item_row(8'($urandom_range(0, 255)), 1'b1));
        send_item(item_row(MARK_FF, 1'b0));
        send_item(item_row(MARK_SOI, 1'b0));
        body = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 20);
        repeat (body) send_item(item_row(random_byte(), 1'b0));
        ending = $urandom_range(0, 99);
        if (ending < 75)
        begin
            send_item(item_row(MARK_FF, 1'b0));
            send_item(item_row(MARK_EOI, 1'b0));
        end
        else if (ending < 85)
        begin
            send_item(item_row(8'($urandom_range(0, 255)), 1'b1));
        end
        else if (ending < 92)
        begin
            send_item(item_row(MARK_FF, 1'b0));
            send_item(item_row(MARK_FF, 1'b0));
            send_item(item_row(MARK_EOI, 1'b0));
        end
    endtask

    always @(posedge clk)
    begin
        frame_beat_t got;
        frame_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            got = '{data: out_byte, opens: frame_start, closes: frame_end,
                    dropped: frame_drop, total: frame_bytes, last: last_of_run};
            if (frame_beats_due.size() == 0)
            begin
                note_mismatch($sformatf({"beat %0d: unexpected byte %02h start %b",
                    " end %b drop %b len %0d last %b"},
                    beats_out, got.data, got.opens, got.closes, got.dropped, got.total,
                    got.last));
            end
            else
            begin
                want = frame_beats_due.pop_front();
                if (got !== want)
                    note_mismatch($sformatf({"beat %0d: expected byte %02h start %b",
                        " end %b drop %b len %0d last %b,",
                        " got byte %02h start %b end %b drop %b len %0d last %b"},
                        beats_out, want.data, want.opens, want.closes, want.dropped,
                        want.total, want.last, got.data, got.opens, got.closes,
                        got.dropped, got.total, got.last));
            end
        end
    end

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_out >= 150)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_stall <= !steady && $urandom_range(0, 99) < 7;
            end
        end
    end

    initial
    begin
        int phase;
        int phase_end;
        bit paused;
        rst_n = 1'b0;
        in_valid = 1'b0;
        byte_value = 8'd0;
        end_of_file = 1'b0;
        cfg_valid = 1'b0;
        max_frame_bytes = 24'd0;
        sent_items = 0;
        beats_out = 0;
        mismatch_count = 0;
        steady = 1'b0;
        len_limit = DEFAULT_MAX_FRAME;
        start_hunt();

        // End of file while hunting, a frame with FF D8 inside it, and end of
        // file clearing the memory of a preceding FF.
        add_row(typed_row(8'h00, 1'b1, 0, '0, '0));
        add_row(typed_row(MARK_FF, 1'b0, 0, '0, '0));
        add_row(typed_row(MARK_SOI, 1'b0, 2, OPEN_FF_BEAT, OPEN_SOI_BEAT));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(item_row(MARK_SOI, 1'b0));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(typed_row(MARK_EOI, 1'b0, 1,
            '{data: MARK_EOI, opens: 1'b0, closes: 1'b1, dropped: 1'b0, total: 24'd6,
              last: 1'b1}, '0));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(typed_row(8'hFF, 1'b1, 0, '0, '0));
        add_row(typed_row(MARK_SOI, 1'b0, 0, '0, '0));
        // Overflow on the first byte after the marker, with limits of two and zero.
        add_row(limit_row(24'd2));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(item_row(MARK_SOI, 1'b0));
        add_row(typed_row(8'h00, 1'b0, 1, DROP_BEAT, '0));
        add_row(limit_row(24'd0));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(item_row(MARK_SOI, 1'b0));
        add_row(typed_row(MARK_FF, 1'b0, 1, DROP_BEAT, '0));
        // The end marker itself is the byte that overflows.
        add_row(limit_row(24'd3));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(item_row(MARK_SOI, 1'b0));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(typed_row(MARK_EOI, 1'b0, 1, DROP_BEAT, '0));
        add_row(limit_row(24'hFFFFFF));
        add_row(item_row(MARK_FF, 1'b0));
        add_row(item_row(MARK_SOI, 1'b0));
        add_row(item_row(8'h00, 1'b0));
        add_row(typed_row(8'hFF, 1'b1, 1, DROP_BEAT, '0));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LIMIT)
                write_limit(directed_rows[i].value);
            else
                send_item(directed_rows[i]);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase < 5)
                write_limit(phase_limits[phase]);
            else
                write_limit(24'($urandom_range(3, 64)));
            steady = (phase == 3);
            phase_end = sent_items + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (sent_items < phase_end)
            begin
                if (phase == 4 && !paused && sent_items >= phase_end - 60)
                begin
                    wait_for_drain();
                    paused = 1'b1;
                end
                send_sequence();
            end
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/mfe_pkg.sv
rtl/mfe_front.sv
rtl/mfe_cmd_fifo.sv
rtl/mfe_back.sv
rtl/mjpeg_frame_extractor.sv
tb/sv/tb_mjpeg_frame_extractor.sv
